// ----- rtl/core/npt_pkg.sv -----
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants for the nearest point table.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int DEF_MAX_POINTS = 512;

    localparam int COORD_W   = 16;
    localparam int LABEL_W   = 8;
    localparam int IDX_OUT_W = 9;
    localparam int CNT_OUT_W = 10;
    localparam int DIST_W    = 2 * COORD_W + 1;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_INHERIT = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LABEL_W-1:0] label;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/core/nearest_point_table.sv -----
// ----------------------------------------------------------------------------
// nearest_point_table
// Table of 2-D points with labels; clear, insert, insert-inherit and
// nearest-point query by linear scan over squared Euclidean distance.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  request | in        | i_in_valid / o_in_stall | command, pos_x, pos_y, label
//  result  | out       | o_out_valid / i_out_stall | status, nearest_index,
//          |           |                         | nearest_label, entry_count
//
//  Clear, insert and failed commands go from accept straight to the result commit.
//  Query and inherit scan the stored points: one point memory read per
//  cycle feeds a 4-stage distance pipeline, which is then drained.
//  Reset empties the table at once; stored points stay undefined until written.
//  A request is taken again as soon as the previous result is in the output
//  register; a stalled result only holds the final commit of the next request.
// ----------------------------------------------------------------------------
module nearest_point_table #(
    parameter int MAX_POINTS = npt_pkg::DEF_MAX_POINTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_command,
    input  logic [npt_pkg::COORD_W-1:0]     i_pos_x,
    input  logic [npt_pkg::COORD_W-1:0]     i_pos_y,
    input  logic [npt_pkg::LABEL_W-1:0]     i_label,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [npt_pkg::IDX_OUT_W-1:0]   o_nearest_index,
    output logic [npt_pkg::LABEL_W-1:0]     o_nearest_label,
    output logic [npt_pkg::CNT_OUT_W-1:0]   o_entry_count
);
    import npt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    npt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    npt_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_label         (i_label),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_nearest_index (o_nearest_index),
        .o_nearest_label (o_nearest_label),
        .o_entry_count   (o_entry_count)
    );

endmodule

// ----- rtl/core/npt_ctrl.sv -----
// ----------------------------------------------------------------------------
// npt_ctrl
// Sequencer: takes a request, runs the table scan when needed, then commits the result.
// ----------------------------------------------------------------------------
module npt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  npt_pkg::t_dp_stat  i_stat,
    output npt_pkg::t_dp_cmd   o_cmd
);
    import npt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = i_stat.need_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                if (i_stat.last_issue) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan_step = (r_state == S_SCAN);
        o_cmd.commit    = (r_state == S_FINISH) && i_stat.out_free;
    end

endmodule

// ----- rtl/core/npt_dp.sv -----
// ----------------------------------------------------------------------------
// npt_dp
// Point memory, distance pipeline, best-match tracking and result register.
// ----------------------------------------------------------------------------
module npt_dp #(
    parameter int MAX_POINTS = npt_pkg::DEF_MAX_POINTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  npt_pkg::t_dp_cmd                i_cmd,
    output npt_pkg::t_dp_stat               o_stat,
    input  logic [1:0]                      i_command,
    input  logic [npt_pkg::COORD_W-1:0]     i_pos_x,
    input  logic [npt_pkg::COORD_W-1:0]     i_pos_y,
    input  logic [npt_pkg::LABEL_W-1:0]     i_label,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [npt_pkg::IDX_OUT_W-1:0]   o_nearest_index,
    output logic [npt_pkg::LABEL_W-1:0]     o_nearest_label,
    output logic [npt_pkg::CNT_OUT_W-1:0]   o_entry_count
);
    import npt_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    t_entry r_mem [MAX_POINTS];

    // request registers
    t_cmd               r_cmd;
    logic [COORD_W-1:0] r_qx;
    logic [COORD_W-1:0] r_qy;
    logic [LABEL_W-1:0] r_qlabel;

    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_addr;

    // distance pipeline
    logic               r_v1, r_v2, r_v3, r_v4;
    t_entry             r_rd;
    logic [IDX_W-1:0]   r_idx1, r_idx2, r_idx3, r_idx4;
    logic [LABEL_W-1:0] r_lab2, r_lab3, r_lab4;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic [2*COORD_W-1:0] r_sqx, r_sqy;
    logic [DIST_W-1:0]  r_dist;

    // best so far
    logic               r_first;
    logic [DIST_W-1:0]  r_best_d;
    logic [IDX_W-1:0]   r_best_idx;
    logic [LABEL_W-1:0] r_best_lab;

    // result register
    logic                 r_out_valid;
    t_status              r_status;
    logic [IDX_OUT_W-1:0] r_idx_out;
    logic [LABEL_W-1:0]   r_lab_out;
    logic [CNT_OUT_W-1:0] r_cnt_out;

    t_status              n_status;
    logic [IDX_OUT_W-1:0] n_idx_out;
    logic [LABEL_W-1:0]   n_lab_out;
    logic [CNT_W-1:0]     n_count;
    logic                 n_wr;
    logic [LABEL_W-1:0]   n_wr_lab;

    logic empty;
    logic full;

    assign empty = (r_count == '0);
    assign full  = (r_count == MAX_CNT);

    always_comb begin
        o_stat.need_scan  = !empty && ((r_cmd == CMD_QUERY) ||
                                       ((r_cmd == CMD_INHERIT) && !full));
        o_stat.last_issue = ((CNT_W'(r_addr) + CNT_W'(1)) == r_count);
        o_stat.pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4;
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= t_cmd'(i_command);
            r_qx     <= i_pos_x;
            r_qy     <= i_pos_y;
            r_qlabel <= i_label;
        end
    end

    // scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_count[IDX_W-1:0]] <= '{x: r_qx, y: r_qy, label: n_wr_lab};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd   <= r_mem[r_addr];
            r_idx1 <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= (r_rd.x > r_qx) ? (r_rd.x - r_qx) : (r_qx - r_rd.x);
        r_dy   <= (r_rd.y > r_qy) ? (r_rd.y - r_qy) : (r_qy - r_rd.y);
        r_idx2 <= r_idx1;
        r_lab2 <= r_rd.label;
        r_sqx  <= r_dx * r_dx;
        r_sqy  <= r_dy * r_dy;
        r_idx3 <= r_idx2;
        r_lab3 <= r_lab2;
        r_dist <= {1'b0, r_sqx} + {1'b0, r_sqy};
        r_idx4 <= r_idx3;
        r_lab4 <= r_lab3;
    end

    // strict less-than keeps the lowest index on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (i_cmd.capture) begin
            r_first <= 1'b1;
        end else if (r_v4) begin
            r_first <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && (r_first || (r_dist < r_best_d))) begin
            r_best_d   <= r_dist;
            r_best_idx <= r_idx4;
            r_best_lab <= r_lab4;
        end
    end

    always_comb begin
        n_status  = STAT_OK;
        n_idx_out = '0;
        n_lab_out = '0;
        n_count   = r_count;
        n_wr      = 1'b0;
        n_wr_lab  = r_qlabel;
        unique case (r_cmd) inside
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_QUERY: begin
                if (empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_idx_out = IDX_OUT_W'(r_best_idx);
                    n_lab_out = r_best_lab;
                end
            end
            CMD_INSERT, CMD_INHERIT: begin
                if ((r_cmd == CMD_INHERIT) && empty) begin
                    n_status = STAT_EMPTY;
                end else if (full) begin
                    n_status = STAT_FULL;
                end else begin
                    if (r_cmd == CMD_INHERIT) n_wr_lab = r_best_lab;
                    n_idx_out = IDX_OUT_W'(r_count);
                    n_lab_out = n_wr_lab;
                    n_count   = r_count + CNT_W'(1);
                    n_wr      = i_cmd.commit;
                end
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_idx_out <= n_idx_out;
            r_lab_out <= n_lab_out;
            r_cnt_out <= CNT_OUT_W'(n_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_nearest_index = r_idx_out;
    assign o_nearest_label = r_lab_out;
    assign o_entry_count   = r_cnt_out;

endmodule

// ----- rtl/core/npt_checker.sv -----
// ----------------------------------------------------------------------------
// npt_checker
// Port-level checks for the nearest point table, bound to the top level.
// ----------------------------------------------------------------------------
module npt_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_stall,
    input  logic [1:0]                      i_command,
    input  logic [npt_pkg::COORD_W-1:0]     i_pos_x,
    input  logic [npt_pkg::COORD_W-1:0]     i_pos_y,
    input  logic [npt_pkg::LABEL_W-1:0]     i_label,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [1:0]                      o_status,
    input  logic [npt_pkg::IDX_OUT_W-1:0]   o_nearest_index,
    input  logic [npt_pkg::LABEL_W-1:0]     o_nearest_label,
    input  logic [npt_pkg::CNT_OUT_W-1:0]   o_entry_count
);
    import npt_pkg::*;

    // a stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_command) &&
            $stable(i_pos_x) && $stable(i_pos_y) && $stable(i_label)))
        else $error("stalled request changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status) &&
            $stable(o_nearest_index) && $stable(o_nearest_label) &&
            $stable(o_entry_count)))
        else $error("stalled result changed");

    // one request in flight: the request side closes right after an accept
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STAT_OK || o_status == STAT_EMPTY ||
                         o_status == STAT_FULL))
        else $error("undefined status code");

    // an empty table reports zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_EMPTY) |->
            (o_nearest_index == '0 && o_nearest_label == '0 &&
             o_entry_count == '0))
        else $error("empty status with non-zero fields");

endmodule

bind nearest_point_table npt_checker u_npt_checker (.*);
